>>> src/csvv_pkg.sv
// Shared widths, types, register codes and reset values for the vertex visibility unit.
package csvv_pkg;

    localparam int POS_W    = 32;
    localparam int ROW_W    = 64;
    localparam int PROD_W   = 64;
    localparam int SUM_W    = 66;
    localparam int MAG_W    = 65;
    localparam int MARGIN_W = 16;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic        [ROW_W-1:0]  t_row;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic        [MAG_W-1:0]  t_mag;
    typedef logic        [MARGIN_W-1:0] t_margin;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_X_ROW_A = 3'd0;
    localparam t_cfg_idx CFG_X_ROW_B = 3'd1;
    localparam t_cfg_idx CFG_Z_ROW_A = 3'd2;
    localparam t_cfg_idx CFG_Z_ROW_B = 3'd3;
    localparam t_cfg_idx CFG_W_ROW_A = 3'd4;
    localparam t_cfg_idx CFG_W_ROW_B = 3'd5;
    localparam t_cfg_idx CFG_MARGIN  = 3'd6;

    localparam t_row    X_ROW_A_RST = 64'h0000_0000_0001_0000;
    localparam t_row    X_ROW_B_RST = 64'h0000_0000_0000_0000;
    localparam t_row    Z_ROW_A_RST = 64'h0000_0000_0000_0000;
    localparam t_row    Z_ROW_B_RST = 64'h0000_0000_0001_0000;
    localparam t_row    W_ROW_A_RST = 64'h0000_0000_0000_0000;
    localparam t_row    W_ROW_B_RST = 64'h0001_0000_0000_0000;
    localparam t_margin MARGIN_RST  = 16'h0000;

endpackage

>>> src/csvv_vtx_if.sv
// Vertex request channel: valid, ready and three Q16.16 coordinates.
interface csvv_vtx_if import csvv_pkg::*; ();
    logic valid;
    logic ready;
    t_pos pos_x;
    t_pos pos_y;
    t_pos pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

>>> src/csvv_vis_if.sv
// Visibility result channel: valid, ready and the visible flag.
interface csvv_vis_if import csvv_pkg::*; ();
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, output visible, input ready);
    modport sink   (input valid, input visible, output ready);
endinterface

>>> src/csvv_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
interface csvv_cfg_if import csvv_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_row     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/csvv_row.sv
// One clip-space matrix row: three products and translation, then their full-width sum.
module csvv_row import csvv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_row  i_row_a,
    input  t_row  i_row_b,
    input  t_pos  i_pos_x,
    input  t_pos  i_pos_y,
    input  t_pos  i_pos_z,
    output t_sum  o_sum
);

    t_pos  w_cx, w_cy, w_cz, w_ct;
    t_prod n_p0, n_p1, n_p2, n_tr;
    t_prod r_p0, r_p1, r_p2, r_tr;
    t_sum  n_sum, r_sum;

    assign w_cx = t_pos'(i_row_a[POS_W-1:0]);
    assign w_cy = t_pos'(i_row_a[ROW_W-1:POS_W]);
    assign w_cz = t_pos'(i_row_b[POS_W-1:0]);
    assign w_ct = t_pos'(i_row_b[ROW_W-1:POS_W]);

    always_comb begin
        n_p0 = PROD_W'(w_cx) * PROD_W'(i_pos_x);
        n_p1 = PROD_W'(w_cy) * PROD_W'(i_pos_y);
        n_p2 = PROD_W'(w_cz) * PROD_W'(i_pos_z);
        n_tr = PROD_W'(w_ct) <<< FRAC_W;
        n_sum = SUM_W'(r_p0) + SUM_W'(r_p1) + SUM_W'(r_p2) + SUM_W'(r_tr);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_tr  <= n_tr;
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> src/clip_space_vertex_visibility_unit.sv
// Throughput: one vertex per cycle unless the output stalls; the nine 32x32 products, the row sums, the
// magnitudes, the margin multiply and the bound compare each take one register stage.
// A stalled output holds every stage in place; nothing is dropped or repeated.
// Reset clears all stage valid bits and loads the identity-like default matrix rows.
module clip_space_vertex_visibility_unit import csvv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csvv_vtx_if.sink     i_vtx,
    csvv_cfg_if.sink     i_cfg,
    csvv_vis_if.source   o_vis
);

    localparam int BND_W = MAG_W + FRAC_W + 1;

    t_row    r_x_row_a, r_x_row_b, r_z_row_a, r_z_row_b, r_w_row_a, r_w_row_b;
    t_margin r_margin;

    logic    w_en;
    logic    r_v1, r_v2, r_v3, r_v4, r_v5;
    t_sum    w_sx, w_sz, w_sw;

    t_mag    n_ax, n_az, n_aw;
    t_mag    r_ax3, r_az3, r_aw3;
    logic    r_wnz3;

    t_mag    r_ax4, r_az4, r_aw4;
    logic    r_wnz4;
    logic [MAG_W+MARGIN_W-1:0] r_mb4;

    logic [BND_W-1:0] w_bound, w_lx, w_lz;
    logic    n_vis, r_vis;

    // config writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_row_a <= X_ROW_A_RST;
            r_x_row_b <= X_ROW_B_RST;
            r_z_row_a <= Z_ROW_A_RST;
            r_z_row_b <= Z_ROW_B_RST;
            r_w_row_a <= W_ROW_A_RST;
            r_w_row_b <= W_ROW_B_RST;
            r_margin  <= MARGIN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_X_ROW_A: r_x_row_a <= i_cfg.data;
                CFG_X_ROW_B: r_x_row_b <= i_cfg.data;
                CFG_Z_ROW_A: r_z_row_a <= i_cfg.data;
                CFG_Z_ROW_B: r_z_row_b <= i_cfg.data;
                CFG_W_ROW_A: r_w_row_a <= i_cfg.data;
                CFG_W_ROW_B: r_w_row_b <= i_cfg.data;
                CFG_MARGIN:  r_margin  <= i_cfg.data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless the output holds an untaken result
    assign w_en        = !r_v5 || o_vis.ready;
    assign i_vtx.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_vtx.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stages 1-2: products and row sums
    csvv_row u_row_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_row_a (r_x_row_a),
        .i_row_b (r_x_row_b),
        .i_pos_x (i_vtx.pos_x),
        .i_pos_y (i_vtx.pos_y),
        .i_pos_z (i_vtx.pos_z),
        .o_sum   (w_sx)
    );

    csvv_row u_row_z (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_row_a (r_z_row_a),
        .i_row_b (r_z_row_b),
        .i_pos_x (i_vtx.pos_x),
        .i_pos_y (i_vtx.pos_y),
        .i_pos_z (i_vtx.pos_z),
        .o_sum   (w_sz)
    );

    csvv_row u_row_w (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_row_a (r_w_row_a),
        .i_row_b (r_w_row_b),
        .i_pos_x (i_vtx.pos_x),
        .i_pos_y (i_vtx.pos_y),
        .i_pos_z (i_vtx.pos_z),
        .o_sum   (w_sw)
    );

    // stage 3: magnitudes (sums stay below 2^64 in magnitude)
    always_comb begin
        n_ax = w_sx[SUM_W-1] ? MAG_W'(-w_sx) : MAG_W'(w_sx);
        n_az = w_sz[SUM_W-1] ? MAG_W'(-w_sz) : MAG_W'(w_sz);
        n_aw = w_sw[SUM_W-1] ? MAG_W'(-w_sw) : MAG_W'(w_sw);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax3  <= n_ax;
            r_az3  <= n_az;
            r_aw3  <= n_aw;
            r_wnz3 <= (w_sw != '0);
        end
    end

    // stage 4: margin times |w|
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax4  <= r_ax3;
            r_az4  <= r_az3;
            r_aw4  <= r_aw3;
            r_wnz4 <= r_wnz3;
            r_mb4  <= (MAG_W+MARGIN_W)'(r_aw3) * (MAG_W+MARGIN_W)'(r_margin);
        end
    end

    // stage 5: |c| * 2^16 <= |w| * 2^16 + margin * |w| for both x and z, and w nonzero
    always_comb begin
        w_bound = BND_W'({r_aw4, {FRAC_W{1'b0}}}) + BND_W'(r_mb4);
        w_lx    = BND_W'({r_ax4, {FRAC_W{1'b0}}});
        w_lz    = BND_W'({r_az4, {FRAC_W{1'b0}}});
        n_vis   = r_wnz4 && (w_lx <= w_bound) && (w_lz <= w_bound);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vis <= n_vis;
        end
    end

    assign o_vis.valid   = r_v5;
    assign o_vis.visible = r_vis;

    a_zero_w_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_v4 && !r_wnz4 |=> !o_vis.visible)
        else $error("zero w produced a visible result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable({r_v1, r_v2, r_v3, r_v4, r_v5}))
        else $error("pipeline valids moved during a stall");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_v4 |=> r_v5)
        else $error("result lost between last two stages");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v5 |-> i_vtx.ready)
        else $error("input stalled with empty output stage");

endmodule

>>> tb/sv/tb_csvv_pkg.sv
// Scoreboard for the vertex visibility unit: register shadow, visibility predictor, result queue.
package tb_csvv_pkg;
    import csvv_pkg::*;

    localparam int MAX_REPORTS = 10;

    class vis_scoreboard;
        t_row    rows[6];
        t_margin margin;
        bit      vis_q[$];
        int      mismatches;
        int      results_seen;

        function new();
            rows[CFG_X_ROW_A] = X_ROW_A_RST;
            rows[CFG_X_ROW_B] = X_ROW_B_RST;
            rows[CFG_Z_ROW_A] = Z_ROW_A_RST;
            rows[CFG_Z_ROW_B] = Z_ROW_B_RST;
            rows[CFG_W_ROW_A] = W_ROW_A_RST;
            rows[CFG_W_ROW_B] = W_ROW_B_RST;
            margin       = MARGIN_RST;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void load_reg(t_cfg_idx idx, t_row data);
            if (idx < CFG_MARGIN) begin
                rows[idx] = data;
            end else if (idx == CFG_MARGIN) begin
                margin = data[MARGIN_W-1:0];
            end
        endfunction

        // One clip coordinate, exact Q32.32: three products plus the translation.
        function logic signed [127:0] clip_coord(t_row ra, t_row rb, t_pos x, t_pos y, t_pos z);
            t_pos kx, ky, kz, kt;
            kx = ra[31:0];
            ky = ra[63:32];
            kz = rb[31:0];
            kt = rb[63:32];
            return 128'(longint'(kx) * longint'(x)) + 128'(longint'(ky) * longint'(y))
                 + 128'(longint'(kz) * longint'(z)) + 128'(longint'(kt) <<< FRAC_W);
        endfunction

        function bit vertex_visible(t_pos x, t_pos y, t_pos z);
            logic signed [127:0] cx, cz, cw;
            logic [127:0] mx, mz, mw, lim;
            cx = clip_coord(rows[CFG_X_ROW_A], rows[CFG_X_ROW_B], x, y, z);
            cz = clip_coord(rows[CFG_Z_ROW_A], rows[CFG_Z_ROW_B], x, y, z);
            cw = clip_coord(rows[CFG_W_ROW_A], rows[CFG_W_ROW_B], x, y, z);
            mx = (cx < 0) ? -cx : cx;
            mz = (cz < 0) ? -cz : cz;
            mw = (cw < 0) ? -cw : cw;
            lim = mw * (128'(1 << FRAC_W) + 128'(margin));
            return (mw != 0) && ((mx << FRAC_W) <= lim) && ((mz << FRAC_W) <= lim);
        endfunction

        function void note_request(t_pos x, t_pos y, t_pos z);
            vis_q.insert(vis_q.size(), vertex_visible(x, y, z));
        endfunction

        function void check_result(logic visible);
            bit want;
            if (vis_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result #%0d: visible=%b", results_seen, visible);
                mismatches++;
            end else begin
                want = vis_q.pop_front();
                if (visible !== want) begin
                    if (mismatches < MAX_REPORTS)
                        $display("result #%0d: visible expected %b, got %b",
                                 results_seen, want, visible);
                    mismatches++;
                end
            end
            results_seen++;
        endfunction

        function int pending();
            return vis_q.size();
        endfunction

        function int failures();
            return mismatches + vis_q.size();
        endfunction
    endclass

endpackage

>>> tb/sv/tb_clip_space_vertex_visibility_unit.sv
// Top-level testbench for the vertex visibility unit: drives vertices and config, checks flags.
module tb_clip_space_vertex_visibility_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import csvv_pkg::*;
    import tb_csvv_pkg::*;

    typedef enum {MIX_SMALL, MIX_FULL, MIX_PERSPECTIVE, MIX_WIDE_MARGIN} t_mix;

    localparam real      CLK_PERIOD_NS   = 4.0;
    localparam int       RESET_CYCLES    = 6;
    localparam int       IDLE_PCT        = 34;
    localparam int       DRAIN_CYCLES    = 12;
    localparam int       WATCHDOG_LIMIT  = 2000;
    localparam int       NUM_PHASES      = 12;
    localparam int       ITEMS_PER_PHASE = 125;
    localparam int       STEADY_PHASE    = 5;
    localparam t_cfg_idx CFG_UNUSED      = 3'd7;
    localparam t_pos     ONE_Q           = 32'sh0001_0000;
    localparam t_pos     HALF_Q          = 32'sh0000_8000;
    localparam t_pos     POS_MAX         = 32'sh7FFF_FFFF;
    localparam t_pos     POS_MIN         = 32'sh8000_0000;

    logic i_clk        = 1'b0;
    logic i_rst_n      = 1'b0;
    logic result_ready = 1'b0;
    bit   steady_flow  = 1'b0;
    int   stall_cycles = 0;
    vis_scoreboard scoreboard = new();

    csvv_vtx_if vtx ();
    csvv_cfg_if cfg ();
    csvv_vis_if vis ();

    assign vis.ready = result_ready;

    clip_space_vertex_visibility_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx),
        .i_cfg   (cfg),
        .o_vis   (vis)
    );

    always #(CLK_PERIOD_NS / 2.0) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        result_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && vis.valid && vis.ready) begin
            scoreboard.check_result(vis.visible);
        end
    end

    always @(posedge i_clk) begin
        if ((vtx.valid && vtx.ready) || (vis.valid && vis.ready) || (cfg.valid && cfg.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // +/-2.0 in Q16.16
    function automatic t_pos near_unit();
        return t_pos'(int'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q);
    endfunction

    function automatic t_row small_row();
        return {near_unit(), near_unit()};
    endfunction

    function automatic t_row full_row();
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_vertex(t_pos x, t_pos y, t_pos z);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            vtx.valid <= 1'b0;
            @(posedge i_clk);
        end
        vtx.valid <= 1'b1;
        vtx.pos_x <= x;
        vtx.pos_y <= y;
        vtx.pos_z <= z;
        do @(posedge i_clk); while (!vtx.ready);
        scoreboard.note_request(x, y, z);
    endtask

    task automatic wait_drained();
        vtx.valid <= 1'b0;
        do @(posedge i_clk); while (scoreboard.pending() != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_row data);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            cfg.valid <= 1'b0;
            @(posedge i_clk);
        end
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        scoreboard.load_reg(idx, data);
    endtask

    task automatic write_one(t_cfg_idx idx, t_row data);
        wait_drained();
        write_reg(idx, data);
        cfg.valid <= 1'b0;
    endtask

    task automatic apply_config(t_row xa, t_row xb, t_row za, t_row zb,
                                t_row wa, t_row wb, t_row marg);
        wait_drained();
        write_reg(CFG_X_ROW_A, xa);
        write_reg(CFG_X_ROW_B, xb);
        write_reg(CFG_Z_ROW_A, za);
        write_reg(CFG_Z_ROW_B, zb);
        write_reg(CFG_W_ROW_A, wa);
        write_reg(CFG_W_ROW_B, wb);
        write_reg(CFG_MARGIN, marg);
        cfg.valid <= 1'b0;
    endtask

    initial begin
        t_mix mode;
        vtx.valid <= 1'b0;
        vtx.pos_x <= '0;
        vtx.pos_y <= '0;
        vtx.pos_z <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_X_ROW_A;
        cfg.data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset matrix: clip x = px, clip z = pz, w = 1.0
        push_vertex(0, 0, 0);
        push_vertex(ONE_Q, 0, ONE_Q);
        push_vertex(-ONE_Q, POS_MIN, -ONE_Q);
        push_vertex(ONE_Q + 1, 0, 0);
        push_vertex(0, POS_MAX, -ONE_Q - 1);
        push_vertex(POS_MAX, POS_MAX, POS_MAX);
        push_vertex(POS_MIN, POS_MIN, POS_MIN);
        push_vertex(-1, -1, -1);

        // write to an unmapped index must leave everything alone
        write_one(CFG_UNUSED, '1);
        push_vertex(ONE_Q, 0, 0);
        push_vertex(ONE_Q + 1, 0, 0);

        // margin 0.5, upper data bits dropped
        write_one(CFG_MARGIN, 64'hFFFF_FFFF_FFFF_8000);
        push_vertex(ONE_Q + HALF_Q, 0, -(ONE_Q + HALF_Q));
        push_vertex(ONE_Q + HALF_Q + 1, 0, 0);

        // w of zero
        write_one(CFG_W_ROW_B, '0);
        push_vertex(0, 0, 0);
        push_vertex(ONE_Q, ONE_Q, ONE_Q);

        // negative w
        write_one(CFG_W_ROW_B, {-ONE_Q, 32'h0});
        push_vertex(0, 0, 0);
        push_vertex(-ONE_Q, 0, ONE_Q);

        apply_config(64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                     64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                     64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000, '1);
        push_vertex(POS_MIN, POS_MIN, POS_MIN);
        push_vertex(POS_MAX, POS_MAX, POS_MAX);
        push_vertex(POS_MAX, POS_MIN, 0);

        apply_config('1, '1, '1, '1, 64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF, '0);
        push_vertex(POS_MAX, POS_MAX, POS_MAX);
        push_vertex(POS_MIN, 0, POS_MAX);
        push_vertex(0, 0, 0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            mode = t_mix'(phase % 4);
            steady_flow = (phase == STEADY_PHASE);
            case (mode)
                MIX_SMALL: begin
                    apply_config(small_row(), small_row(), small_row(), small_row(),
                                 small_row(), small_row(), t_row'($urandom_range(0, 16'h3FFF)));
                end
                MIX_FULL: begin
                    apply_config(full_row(), full_row(), full_row(), full_row(),
                                 full_row(), full_row(), full_row());
                end
                MIX_PERSPECTIVE: begin
                    apply_config(small_row(), small_row(), small_row(), small_row(), '0,
                                 {t_pos'($urandom_range(ONE_Q, 4 * ONE_Q)), near_unit()},
                                 t_row'($urandom_range(0, 16'h1FFF)));
                end
                default: begin
                    apply_config(small_row(), small_row(), small_row(), small_row(),
                                 small_row(), small_row(), {48'($urandom()), 16'hFFFF});
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(199) == 0) begin
                    wait_drained();
                end
                if (mode == MIX_FULL || $urandom_range(9) < 3) begin
                    push_vertex($urandom(), $urandom(), $urandom());
                end else begin
                    push_vertex(near_unit(), near_unit(), near_unit());
                end
            end
        end
        steady_flow = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.failures() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
